>>> rtl/core/hsl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the HSL to RGB converter.
// No dependencies; every module of the converter imports this package.
package hsl_pkg;

  // Item formats
  typedef struct packed {
    logic [15:0] hue_degrees;
    logic [8:0]  saturation;
    logic [8:0]  lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsl_out_t;

  // Hue in whole degrees, always below 360
  typedef logic [8:0] deg_t;
  // Unsigned Q.16 fraction, 65536 is 1.0
  typedef logic [16:0] qfrac_t;

  typedef struct packed {
    qfrac_t p;
    qfrac_t q;
  } hsl_pq_t;

  // Degree wrapping
  localparam int unsigned DegFull      = 360;
  localparam int unsigned DegThird     = 120;
  localparam int unsigned DegTwoThird  = 240;
  // floor(2^24 / 360): quotient estimate is low by at most one
  localparam int unsigned HueRecip      = 46603;
  localparam int unsigned HueRecipShift = 24;
  localparam int unsigned QuotW         = 32 - HueRecipShift;

  // floor(d * 65536 / 360) = 182 * d + floor(2 * d / 45)
  localparam int unsigned HueScale     = 182;
  // ceil(2^16 / 45), exact for 2 * d below 720
  localparam int unsigned HueFracRecip = 1457;
  localparam int unsigned HueFracShift = 16;

  // Q.16 constants
  localparam int unsigned QOne     = 65536;
  localparam int unsigned QHalf    = 32768;
  localparam int unsigned FallBase = 4 * QOne;

  // Q.8 input range
  localparam int unsigned FracMax  = 256;
  localparam int unsigned HalfQ8   = 128;

  localparam int unsigned ChanScale = 255;
  localparam int unsigned Latency   = 6;

endpackage

>>> rtl/core/hsl_hue_reduce.sv
`timescale 1ns / 1ps
// Hue front end: reduces the hue modulo 360 and forms the three channel angles.
// Three register stages; depends on hsl_pkg.
module hsl_hue_reduce (
  input  logic          clk_i,
  input  logic [15:0]   hue_i,
  output hsl_pkg::deg_t deg_r_o,
  output hsl_pkg::deg_t deg_g_o,
  output hsl_pkg::deg_t deg_b_o
);
  import hsl_pkg::*;

  logic [31:0] prod_d, prod_q;
  logic [15:0] hue_q;
  logic [QuotW-1:0] quot;
  logic [16:0] rem;
  deg_t deg_d, deg_q;
  logic [9:0] sum_r, sum_b;
  deg_t deg_r_d, deg_b_d, deg_r_q, deg_g_q, deg_b_q;

  // Stage 1: reciprocal product for the quotient estimate
  assign prod_d = 32'(hue_i) * 32'(HueRecip);

  // Stage 2: remainder, one correction step
  assign quot  = prod_q[31:HueRecipShift];
  assign rem   = 17'(hue_q) - 17'(17'(quot) * 17'(DegFull));
  assign deg_d = (rem >= 17'(DegFull)) ? 9'(rem - 17'(DegFull)) : 9'(rem);

  // Stage 3: offsets of a third and two thirds of a turn, wrapped
  assign sum_r   = 10'(deg_q) + 10'(DegThird);
  assign sum_b   = 10'(deg_q) + 10'(DegTwoThird);
  assign deg_r_d = (sum_r >= 10'(DegFull)) ? 9'(sum_r - 10'(DegFull)) : 9'(sum_r);
  assign deg_b_d = (sum_b >= 10'(DegFull)) ? 9'(sum_b - 10'(DegFull)) : 9'(sum_b);

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    hue_q   <= hue_i;
    deg_q   <= deg_d;
    deg_r_q <= deg_r_d;
    deg_g_q <= deg_q;
    deg_b_q <= deg_b_d;
  end

  assign deg_r_o = deg_r_q;
  assign deg_g_o = deg_g_q;
  assign deg_b_o = deg_b_q;

endmodule

>>> rtl/core/hsl_chroma.sv
`timescale 1ns / 1ps
// Forms the HSL q and p levels from saturation and lightness.
// Four register stages to line up with the hue path; depends on hsl_pkg.
module hsl_chroma (
  input  logic            clk_i,
  input  logic [8:0]      saturation_i,
  input  logic [8:0]      lightness_i,
  output hsl_pkg::hsl_pq_t pq_o
);
  import hsl_pkg::*;

  logic [8:0]  s8_d, l8_d, s8_q, l8_q;
  logic [17:0] ls_d;
  logic [16:0] ls_q;
  qfrac_t      s16, l16;
  logic [17:0] q_wide, p_wide;
  hsl_pq_t     pq_d, pq_q, pq_dly1_q, pq_dly2_q;

  // Stage 1: clamp to one, l*s in Q.16 is exactly l8*s8
  assign s8_d = (saturation_i > 9'(FracMax)) ? 9'(FracMax) : saturation_i;
  assign l8_d = (lightness_i > 9'(FracMax)) ? 9'(FracMax) : lightness_i;
  assign ls_d = 18'(s8_d) * 18'(l8_d);

  // Stage 2: q and p, both exact
  assign s16    = {s8_q, 8'b0};
  assign l16    = {l8_q, 8'b0};
  assign q_wide = (l8_q < 9'(HalfQ8)) ? 18'(l16) + 18'(ls_q)
                                       : 18'(l16) + 18'(s16) - 18'(ls_q);
  assign p_wide = {l16, 1'b0} - q_wide;
  assign pq_d.q = 17'(q_wide);
  assign pq_d.p = 17'(p_wide);

  // Stages 3 and 4: hold while the hue angles are formed
  always_ff @(posedge clk_i) begin
    s8_q      <= s8_d;
    l8_q      <= l8_d;
    ls_q      <= 17'(ls_d);
    pq_q      <= pq_d;
    pq_dly1_q <= pq_q;
    pq_dly2_q <= pq_dly1_q;
  end

  assign pq_o = pq_dly2_q;

endmodule

>>> rtl/core/hsl_channel.sv
`timescale 1ns / 1ps
// One color channel: hue angle to Q.16 position, piecewise level, 8-bit byte.
// Three register stages; depends on hsl_pkg.
module hsl_channel (
  input  logic             clk_i,
  input  hsl_pkg::deg_t    deg_i,
  input  hsl_pkg::hsl_pq_t pq_i,
  output logic [7:0]       chan_o
);
  import hsl_pkg::*;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HOLD,
    SEG_FALL,
    SEG_LOW
  } seg_e;

  logic [20:0] fine_prod;
  logic [16:0] t_wide;
  logic [15:0] t_q;
  logic [18:0] six_t;
  seg_e        seg_d, seg_q;
  qfrac_t      diff, factor;
  logic [33:0] ramp_prod;
  qfrac_t      ramp_q;
  hsl_pq_t     pq_q;
  logic [17:0] level_sum;
  qfrac_t      level;
  logic [24:0] scaled;
  logic [7:0]  chan_q;

  // Stage 4: t = floor(d * 65536 / 360)
  assign fine_prod = 21'({deg_i, 1'b0}) * 21'(HueFracRecip);
  assign t_wide    = 17'(17'(deg_i) * 17'(HueScale)) + 17'(fine_prod[20:HueFracShift]);

  // Stage 5: segment choice and ramp product
  assign six_t = 19'(t_q) * 19'(6);
  assign diff  = pq_i.q - pq_i.p;

  always_comb begin
    if (six_t < 19'(QOne)) begin
      seg_d  = SEG_RISE;
      factor = 17'(six_t);
    end else if (t_q < 16'(QHalf)) begin
      seg_d  = SEG_HOLD;
      factor = '0;
    end else if (six_t < 19'(FallBase)) begin
      seg_d  = SEG_FALL;
      factor = 17'(19'(FallBase) - six_t);
    end else begin
      seg_d  = SEG_LOW;
      factor = '0;
    end
  end

  assign ramp_prod = 34'(diff) * 34'(factor);

  // Stage 6: level and floor(255 * level)
  assign level_sum = 18'(pq_q.p) + 18'(ramp_q);

  always_comb begin
    case (seg_q) inside
      SEG_RISE, SEG_FALL: level = 17'(level_sum);
      SEG_HOLD:           level = pq_q.q;
      default:            level = pq_q.p;
    endcase
  end

  assign scaled = 25'({level, 8'b0}) - 25'(level);

  always_ff @(posedge clk_i) begin
    t_q    <= 16'(t_wide);
    seg_q  <= seg_d;
    ramp_q <= 17'(ramp_prod[33:16]);
    pq_q   <= pq_i;
    chan_q <= scaled[23:16];
  end

  assign chan_o = chan_q;

endmodule

>>> rtl/core/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// HSL to RGB converter, six-stage pipeline; depends on hsl_pkg and the hsl_* modules.
// Each accepted beat runs down the valid chain beside its data and leaves on valid_o.
// Throughput: one beat per cycle; busy_o stays low, nothing in the path stalls.
// The receiver cannot hold results off, so each result shows for one cycle only.
// Reset clears the valid bits only; the datapath registers carry no reset.
module hsl_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hsl_pkg::hsl_in_t  hsl_i,
  output logic              busy_o,
  output logic              valid_o,
  output hsl_pkg::hsl_out_t rgb_o
);
  import hsl_pkg::*;

  logic [Latency-1:0] valid_d, valid_q;
  deg_t               deg_r, deg_g, deg_b;
  hsl_pq_t            pq;

  assign busy_o  = 1'b0;
  assign valid_d = {valid_q[Latency-2:0], start_i & ~busy_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  hsl_hue_reduce u_hue (
    .clk_i   (clk_i),
    .hue_i   (hsl_i.hue_degrees),
    .deg_r_o (deg_r),
    .deg_g_o (deg_g),
    .deg_b_o (deg_b)
  );

  hsl_chroma u_chroma (
    .clk_i        (clk_i),
    .saturation_i (hsl_i.saturation),
    .lightness_i  (hsl_i.lightness),
    .pq_o         (pq)
  );

  hsl_channel u_red (
    .clk_i  (clk_i),
    .deg_i  (deg_r),
    .pq_i   (pq),
    .chan_o (rgb_o.red)
  );

  hsl_channel u_green (
    .clk_i  (clk_i),
    .deg_i  (deg_g),
    .pq_i   (pq),
    .chan_o (rgb_o.green)
  );

  hsl_channel u_blue (
    .clk_i  (clk_i),
    .deg_i  (deg_b),
    .pq_i   (pq),
    .chan_o (rgb_o.blue)
  );

  assign valid_o = valid_q[Latency-1];

endmodule
